// File: src/ecc_pkg.sv
package ecc_pkg;

    // event kinds
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_SERVICE = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_START   = 2'd3;

    // directions and request kinds
    localparam logic [1:0] DIR_DOWN    = 2'd0;
    localparam logic [1:0] DIR_UP      = 2'd1;
    localparam logic [1:0] DIR_IDLE    = 2'd2;
    localparam logic [1:0] KIND_INSIDE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INSIDE_IDLE = 3'd1;
    localparam logic [2:0] ST_WRONG_DIR   = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_TICK_IDLE   = 3'd4;

    localparam logic [3:0] FLOOR_GROUND    = 4'd1;
    localparam logic [3:0] FLOOR_FIRST_UP  = 4'd2;
    localparam logic [3:0] TOP_FLOOR_RESET = 4'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] floor;
        logic [1:0] req_dir;
    } req_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] car_floor;
        logic [1:0] car_dir;
        logic [3:0] pending;
        logic [3:0] next_floor;
        logic [1:0] next_kind;
    } rsp_word_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

// File: src/ecc_ctrl.sv
module ecc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ecc_pkg::dp_cmd_t  cmd
);

    ecc_pkg::ctrl_state_t state_reg;
    ecc_pkg::ctrl_state_t state_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 out_free;

    // output register is free when empty or being taken this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecc_pkg::CTRL_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ecc_pkg::CTRL_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ecc_pkg::CTRL_EXEC;
                end
            end
            ecc_pkg::CTRL_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ecc_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = ecc_pkg::CTRL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall      = 1'b1;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ecc_pkg::CTRL_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ecc_pkg::CTRL_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// File: src/ecc_dp.sv
module ecc_dp
#(
    parameter int MAX_PENDING = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ecc_pkg::dp_cmd_t    cmd,
    input  ecc_pkg::req_word_t  req,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata,
    output ecc_pkg::rsp_word_t  rsp
);

    localparam int CW = $clog2(MAX_PENDING + 1);
    localparam int HW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

    ecc_pkg::req_word_t item_reg;
    ecc_pkg::rsp_word_t rsp_reg;
    ecc_pkg::rsp_word_t rsp_next;

    logic [3:0]    top_floor_reg;
    logic [3:0]    cur_floor_reg;
    logic [3:0]    cur_floor_next;
    logic [1:0]    dir_reg;
    logic [1:0]    dir_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [HW-1:0] head_reg;
    logic [HW-1:0] head_next;
    logic [3:0]    nd_floor_reg;
    logic [3:0]    nd_floor_next;
    logic [1:0]    nd_kind_reg;
    logic [1:0]    nd_kind_next;
    logic [2:0]    status_next;

    logic [3:0]    queue_floor_reg [MAX_PENDING];
    logic [1:0]    queue_kind_reg  [MAX_PENDING];

    logic          q_we;
    logic [1:0]    q_wkind;
    logic [HW-1:0] head_inc;
    logic [CW:0]   slot_sum;
    logic [HW-1:0] tail;
    logic          ahead;

    // ring buffer pointers: next head and the free slot after the last entry
    assign head_inc = (head_reg == HW'(MAX_PENDING - 1)) ? '0 : head_reg + HW'(1);
    assign slot_sum = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign tail     = (slot_sum >= (CW + 1)'(MAX_PENDING))
                      ? HW'(slot_sum - (CW + 1)'(MAX_PENDING))
                      : HW'(slot_sum);

    assign ahead = (dir_reg == ecc_pkg::DIR_UP && cur_floor_reg < item_reg.floor) ||
                   (dir_reg == ecc_pkg::DIR_DOWN && cur_floor_reg > item_reg.floor);

    always_comb
    begin
        cur_floor_next = cur_floor_reg;
        dir_next       = dir_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        nd_floor_next  = nd_floor_reg;
        nd_kind_next   = nd_kind_reg;
        status_next    = ecc_pkg::ST_OK;
        q_we           = 1'b0;
        q_wkind        = item_reg.req_dir;
        case (item_reg.cmd)
            ecc_pkg::CMD_ADD:
            begin
                if (item_reg.req_dir == ecc_pkg::KIND_INSIDE)
                begin
                    // a non-empty queue silently drops inside requests
                    if (count_reg == '0)
                    begin
                        if (dir_reg == ecc_pkg::DIR_IDLE)
                        begin
                            status_next = ecc_pkg::ST_INSIDE_IDLE;
                        end
                        else if (ahead)
                        begin
                            q_we          = 1'b1;
                            q_wkind       = dir_reg;
                            count_next    = count_reg + CW'(1);
                            nd_floor_next = item_reg.floor;
                            nd_kind_next  = dir_reg;
                        end
                        else
                        begin
                            status_next = ecc_pkg::ST_WRONG_DIR;
                        end
                    end
                end
                else if (count_reg == '0)
                begin
                    q_we          = 1'b1;
                    count_next    = count_reg + CW'(1);
                    nd_floor_next = item_reg.floor;
                    nd_kind_next  = item_reg.req_dir;
                end
                else if (count_reg < CW'(MAX_PENDING))
                begin
                    q_we       = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    status_next = ecc_pkg::ST_FULL;
                end
            end
            ecc_pkg::CMD_SERVICE:
            begin
                if (nd_kind_reg == ecc_pkg::DIR_IDLE)
                begin
                    dir_next = ecc_pkg::DIR_IDLE;
                end
                if (count_reg != '0)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                    // destination kept when the queue runs empty
                    if (count_reg != CW'(1))
                    begin
                        nd_floor_next = queue_floor_reg[head_inc];
                        nd_kind_next  = queue_kind_reg[head_inc];
                    end
                end
            end
            ecc_pkg::CMD_TICK:
            begin
                if (dir_reg == ecc_pkg::DIR_UP)
                begin
                    if (cur_floor_reg >= top_floor_reg)
                    begin
                        dir_next = ecc_pkg::DIR_DOWN;
                    end
                    else
                    begin
                        cur_floor_next = cur_floor_reg + 4'd1;
                    end
                end
                else if (dir_reg == ecc_pkg::DIR_DOWN)
                begin
                    if (cur_floor_reg == ecc_pkg::FLOOR_FIRST_UP &&
                        nd_kind_reg == ecc_pkg::DIR_IDLE)
                    begin
                        cur_floor_next = ecc_pkg::FLOOR_GROUND;
                        dir_next       = ecc_pkg::DIR_IDLE;
                    end
                    else if (cur_floor_reg > ecc_pkg::FLOOR_GROUND)
                    begin
                        cur_floor_next = cur_floor_reg - 4'd1;
                    end
                    else
                    begin
                        dir_next = ecc_pkg::DIR_IDLE;
                    end
                end
                else
                begin
                    status_next = ecc_pkg::ST_TICK_IDLE;
                end
            end
            ecc_pkg::CMD_START:
            begin
                if (item_reg.req_dir != ecc_pkg::KIND_INSIDE)
                begin
                    dir_next = item_reg.req_dir;
                end
            end
            default:
            begin
                status_next = ecc_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.status     = status_next;
        rsp_next.car_floor  = cur_floor_next;
        rsp_next.car_dir    = dir_next;
        rsp_next.pending    = 4'(count_next);
        rsp_next.next_floor = nd_floor_next;
        rsp_next.next_kind  = nd_kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_floor_reg <= ecc_pkg::TOP_FLOOR_RESET;
            cur_floor_reg <= ecc_pkg::FLOOR_GROUND;
            dir_reg       <= ecc_pkg::DIR_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            nd_floor_reg  <= ecc_pkg::FLOOR_GROUND;
            nd_kind_reg   <= ecc_pkg::DIR_DOWN;
        end
        else
        begin
            if (cfg_we)
            begin
                top_floor_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                cur_floor_reg <= cur_floor_next;
                dir_reg       <= dir_next;
                count_reg     <= count_next;
                head_reg      <= head_next;
                nd_floor_reg  <= nd_floor_next;
                nd_kind_reg   <= nd_kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
        if (cmd.commit && q_we)
        begin
            queue_floor_reg[tail] <= item_reg.floor;
            queue_kind_reg[tail]  <= q_wkind;
        end
    end

    assign rsp = rsp_reg;

endmodule

// File: src/elevator_car_controller.sv
// One elevator car: each event word is first registered, then applied to the car state and the
// request fifo (held in flip-flops, MAX_PENDING deep) while the result is loaded into the output
// register; no new word is taken until the last one has been applied. The input stalls while a
// word is being applied, and also while the output register is still full and stalled, but a new
// word is taken while a finished result waits. top_floor is written through cfg_we/cfg_wdata and
// should only change while no word is in flight.
module elevator_car_controller
#(
    parameter int MAX_PENDING = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ecc_pkg::req_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ecc_pkg::rsp_word_t  rsp,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata
);

    ecc_pkg::dp_cmd_t dp_cmd;

    ecc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (dp_cmd)
    );

    ecc_dp
    #(
        .MAX_PENDING (MAX_PENDING)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

`ifndef ASSERT_OFF
    a_commit_free : assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |-> !(rsp_valid && rsp_stall))
        else $error("result overwritten while stalled");

    a_commit_valid : assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |=> rsp_valid)
        else $error("result not presented after apply");

    a_capture_stall : assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.capture |=> req_stall)
        else $error("input open while a word is being applied");

    a_pending_range : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (MAX_PENDING > 15 || rsp.pending <= 4'(MAX_PENDING)))
        else $error("pending count beyond queue depth");
`endif

endmodule
